@@ src/ols_pkg.sv @@
// shared types, codes and constants of the ordered list store
`timescale 1ns / 1ps
package ols_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int KIND_W = 3;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int STAT_W = 3;
  localparam int FIDX_W = 4;
  localparam int CNT_OUT_W = 5;

  localparam logic [KIND_W-1:0] K_PUSH_BACK = 3'd0;
  localparam logic [KIND_W-1:0] K_POP_BACK = 3'd1;
  localparam logic [KIND_W-1:0] K_PUSH_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] K_POP_FRONT = 3'd3;
  localparam logic [KIND_W-1:0] K_INSERT = 3'd4;
  localparam logic [KIND_W-1:0] K_ERASE = 3'd5;
  localparam logic [KIND_W-1:0] K_FIND = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [FIDX_W-1:0]    found_index;
    logic [CNT_OUT_W-1:0] element_count;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_APPEND,
    OP_DROP,
    OP_UP_INIT,
    OP_UP_STEP,
    OP_UP_PUT,
    OP_DN_INIT,
    OP_DN_STEP,
    OP_DN_END,
    OP_SC_INIT,
    OP_SC_STEP,
    OP_SC_HIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic              res_load;
    logic [STAT_W-1:0] res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              empty;
    logic              pos_over;
    logic              pos_atleast;
    logic              up_more;
    logic              dn_more;
    logic              sc_more;
    logic              pend;
    logic              match;
  } dp_sts_t;

endpackage

@@ src/ols_datapath.sv @@
// list memory, count, shift and scan cursors and result register
`timescale 1ns / 1ps
module ols_datapath import ols_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_r;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        ptr_r, ptr_nxt;
  logic [AW-1:0]           wptr_r, wptr_nxt;
  logic                    pend_r, pend_nxt;
  logic [KIND_W-1:0]       kind_r, kind_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [AW-1:0]           found_r, found_nxt;
  out_item_t               out_r, out_nxt;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [CNT_W-1:0] pos_cnt;
  logic [CNT_W:0]   ptr_inc;

  assign pos_cnt = CNT_W'(pos_r);
  assign ptr_inc = {1'b0, ptr_r} + 1'b1;

  assign sts.kind        = kind_r;
  assign sts.full        = (count_r == CNT_W'(CAPACITY));
  assign sts.empty       = (count_r == '0);
  assign sts.pos_over    = (CW'(pos_r) > CW'(count_r));
  assign sts.pos_atleast = (CW'(pos_r) >= CW'(count_r));
  assign sts.up_more     = (ptr_r > pos_cnt);
  assign sts.dn_more     = (ptr_inc < {1'b0, count_r});
  assign sts.sc_more     = (ptr_r < count_r);
  assign sts.pend        = pend_r;
  assign sts.match       = pend_r && (rdata_r == $unsigned(val_r));

  always_comb begin
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    wptr_nxt  = wptr_r;
    pend_nxt  = pend_r;
    kind_nxt  = kind_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    found_nxt = found_r;
    out_nxt   = out_r;
    we        = 1'b0;
    waddr     = wptr_r;
    wdata     = rdata_r;
    raddr     = '0;
    unique case (cmd.op)
      OP_LOAD: begin
        kind_nxt  = in_data.kind;
        val_nxt   = in_data.value;
        found_nxt = '0;
        if (in_data.kind == K_PUSH_FRONT || in_data.kind == K_POP_FRONT) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = in_data.position;
        end
      end
      OP_APPEND: begin
        we        = 1'b1;
        waddr     = AW'(count_r);
        wdata     = $unsigned(val_r);
        count_nxt = count_r + 1'b1;
      end
      OP_DROP: begin
        count_nxt = count_r - 1'b1;
      end
      OP_UP_INIT: begin
        ptr_nxt  = count_r;
        pend_nxt = 1'b0;
      end
      OP_UP_STEP: begin
        we = pend_r;
        if (sts.up_more) begin
          raddr    = AW'(ptr_r - 1'b1);
          wptr_nxt = AW'(ptr_r);
          ptr_nxt  = ptr_r - 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      OP_UP_PUT: begin
        we        = 1'b1;
        waddr     = AW'(pos_cnt);
        wdata     = $unsigned(val_r);
        count_nxt = count_r + 1'b1;
      end
      OP_DN_INIT: begin
        ptr_nxt  = pos_cnt;
        pend_nxt = 1'b0;
      end
      OP_DN_STEP: begin
        we = pend_r;
        if (sts.dn_more) begin
          raddr    = AW'(ptr_inc);
          wptr_nxt = AW'(ptr_r);
          ptr_nxt  = CNT_W'(ptr_inc);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      OP_DN_END: begin
        count_nxt = count_r - 1'b1;
      end
      OP_SC_INIT: begin
        ptr_nxt  = '0;
        pend_nxt = 1'b0;
      end
      OP_SC_STEP: begin
        if (sts.sc_more) begin
          raddr    = AW'(ptr_r);
          wptr_nxt = AW'(ptr_r);
          ptr_nxt  = ptr_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      OP_SC_HIT: begin
        found_nxt = wptr_r;
        pend_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
    if (cmd.res_load) begin
      out_nxt.status        = cmd.res_status;
      out_nxt.found_index   = FIDX_W'(found_r);
      out_nxt.element_count = CNT_OUT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    wptr_r  <= wptr_nxt;
    kind_r  <= kind_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    found_r <= found_nxt;
    out_r   <= out_nxt;
  end

  assign out_data = out_r;

endmodule

@@ src/ols_controller.sv @@
// request sequencer and result handshake of the ordered list store
`timescale 1ns / 1ps
module ols_controller import ols_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_UP    = 6'b000100,
    S_DN    = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STAT_W-1:0] st_r, st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd.op         = OP_IDLE;
    cmd.res_load   = 1'b0;
    cmd.res_status = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_DONE;
        st_nxt    = ST_OK;
        unique case (sts.kind)
          K_PUSH_BACK: begin
            if (sts.full) begin
              st_nxt = ST_FULL;
            end else begin
              cmd.op = OP_APPEND;
            end
          end
          K_POP_BACK: begin
            if (sts.empty) begin
              st_nxt = ST_EMPTY;
            end else begin
              cmd.op = OP_DROP;
            end
          end
          K_PUSH_FRONT, K_INSERT: begin
            priority if (sts.full) begin
              st_nxt = ST_FULL;
            end else if (sts.pos_over) begin
              st_nxt = ST_BADPOS;
            end else begin
              cmd.op    = OP_UP_INIT;
              state_nxt = S_UP;
            end
          end
          K_POP_FRONT, K_ERASE: begin
            priority if (sts.empty) begin
              st_nxt = ST_EMPTY;
            end else if (sts.pos_atleast) begin
              st_nxt = ST_BADPOS;
            end else begin
              cmd.op    = OP_DN_INIT;
              state_nxt = S_DN;
            end
          end
          K_FIND: begin
            st_nxt    = ST_NOTFOUND;
            cmd.op    = OP_SC_INIT;
            state_nxt = S_SCAN;
          end
          default: begin
          end
        endcase
      end
      S_UP: begin
        if (sts.pend || sts.up_more) begin
          cmd.op = OP_UP_STEP;
        end else begin
          cmd.op    = OP_UP_PUT;
          state_nxt = S_DONE;
        end
      end
      S_DN: begin
        if (sts.pend || sts.dn_more) begin
          cmd.op = OP_DN_STEP;
        end else begin
          cmd.op    = OP_DN_END;
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        priority if (sts.match) begin
          cmd.op    = OP_SC_HIT;
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end else if (sts.pend || sts.sc_more) begin
          cmd.op = OP_SC_STEP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      st_r        <= ST_OK;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

endmodule

@@ src/ordered_list_store.sv @@
// top level of the ordered list store
// Push back, pop back, an unused kind and any rejected request go from the check straight to
// the result. Insert, push front, erase and pop front shift n entries, which may be none: n
// is count - position for an insert and count - position - 1 for an erase, with position 0
// for the front operations. A find compares the entries from the first one on and stops at
// the first match, or after the last entry when nothing matches. How long a request occupies
// the block is set by the list memory, which has one read port and one write port: while
// entries shift, one entry is read and one is written per cycle, and during a find one entry
// is read per cycle. A new item is taken once the previous one has been written into the
// result register, so the next request can start while an earlier result is still waiting
// on out_stall.
`timescale 1ns / 1ps
module ordered_list_store import ols_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ols_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ols_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

@@ src/ols_checker.sv @@
// port-level assertions for the ordered list store and their bind
`timescale 1ns / 1ps
module ols_checker import ols_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.element_count) <= CAPACITY))
    else $error("element count above capacity");

  a_found_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.found_index != '0) |-> (out_data.status == ST_OK))
    else $error("found index set on a failed request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken before the first was processed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result item changed");

endmodule

bind ordered_list_store ols_checker #(.CAPACITY(CAPACITY)) u_ols_checker (.*);

@@ test/ordered_list_store_test.sv @@
// self-checking testbench of the ordered list store: directed and random requests, scoreboard
`timescale 1ns / 1ps
module ordered_list_store_test;
  import ols_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam logic [KIND_W-1:0] K_UNUSED = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic signed [VAL_W-1:0] list_model [CAPACITY];
  int        list_count = 0;
  out_item_t expected_results [$];
  out_item_t expected_head;
  int        error_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  bit        grow = 1'b1;

  ordered_list_store #(.CAPACITY(CAPACITY)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ordered_list_store_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: status %0d found_index %0d count %0d",
               out_data.status, out_data.found_index, out_data.element_count);
        error_count++;
      end else begin
        expected_head = expected_results.pop_front();
        if (out_data.status !== expected_head.status) begin
          $error("status expected %0d got %0d", expected_head.status, out_data.status);
          error_count++;
        end
        if (out_data.found_index !== expected_head.found_index) begin
          $error("found_index expected %0d got %0d",
                 expected_head.found_index, out_data.found_index);
          error_count++;
        end
        if (out_data.element_count !== expected_head.element_count) begin
          $error("element_count expected %0d got %0d",
                 expected_head.element_count, out_data.element_count);
          error_count++;
        end
      end
    end
  end

  function automatic out_item_t list_predict(in_item_t item);
    out_item_t res;
    int        pos;
    int        i;
    pos = item.position;
    res.status = ST_OK;
    res.found_index = '0;
    case (item.kind)
      K_PUSH_BACK: begin
        if (list_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_model[list_count] = item.value;
          list_count++;
        end
      end
      K_POP_BACK: begin
        if (list_count == 0) res.status = ST_EMPTY;
        else list_count--;
      end
      K_PUSH_FRONT, K_INSERT: begin
        if (item.kind == K_PUSH_FRONT) pos = 0;
        if (list_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (pos > list_count) begin
          res.status = ST_BADPOS;
        end else begin
          for (i = list_count; i > pos; i--) list_model[i] = list_model[i-1];
          list_model[pos] = item.value;
          list_count++;
        end
      end
      K_POP_FRONT, K_ERASE: begin
        if (item.kind == K_POP_FRONT) pos = 0;
        if (list_count == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= list_count) begin
          res.status = ST_BADPOS;
        end else begin
          for (i = pos; i + 1 < list_count; i++) list_model[i] = list_model[i+1];
          list_count--;
        end
      end
      K_FIND: begin
        res.status = ST_NOTFOUND;
        for (i = 0; i < list_count; i++) begin
          if (list_model[i] == item.value) begin
            res.status = ST_OK;
            res.found_index = i[FIDX_W-1:0];
            break;
          end
        end
      end
      default: begin
      end
    endcase
    res.element_count = list_count[CNT_OUT_W-1:0];
    return res;
  endfunction

  function automatic in_item_t make_item(logic [KIND_W-1:0] kind, int pos,
                                         logic signed [VAL_W-1:0] value);
    in_item_t item;
    item.kind = kind;
    item.position = pos[POS_W-1:0];
    item.value = value;
    return item;
  endfunction

  task automatic send_item(in_item_t item);
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(list_predict(item));
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  task automatic send(logic [KIND_W-1:0] kind, int pos, logic signed [VAL_W-1:0] value);
    send_item(make_item(kind, pos, value));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $signed(32'($urandom_range(3))) - 1;
      4: return 32'sh8000_0000;
      5: return 32'sh7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(99);
    if (grow) begin
      if (r < 25) return K_PUSH_BACK;
      if (r < 40) return K_PUSH_FRONT;
      if (r < 60) return K_INSERT;
      if (r < 67) return K_POP_BACK;
      if (r < 73) return K_POP_FRONT;
      if (r < 82) return K_ERASE;
      if (r < 97) return K_FIND;
    end else begin
      if (r < 7) return K_PUSH_BACK;
      if (r < 13) return K_PUSH_FRONT;
      if (r < 20) return K_INSERT;
      if (r < 40) return K_POP_BACK;
      if (r < 55) return K_POP_FRONT;
      if (r < 78) return K_ERASE;
      if (r < 97) return K_FIND;
    end
    return K_UNUSED;
  endfunction

  task automatic test_empty_list();
    send(K_POP_BACK, 0, 0);
    send(K_POP_FRONT, 0, 0);
    send(K_ERASE, 0, 0);
    send(K_FIND, 0, 0);
    send(K_INSERT, 1, 5);
    send(K_UNUSED, 31, 32'sh7fff_ffff);
    wait_drained();
  endtask

  task automatic test_basic_ops();
    send(K_INSERT, 0, 32'sh8000_0000);
    send(K_PUSH_BACK, 0, 32'sh7fff_ffff);
    send(K_PUSH_FRONT, 16, 0);
    send(K_INSERT, 3, -1);
    send(K_INSERT, 31, 9);
    send(K_ERASE, 4, 0);
    send(K_ERASE, 16, 0);
    send(K_FIND, 0, 32'sh7fff_ffff);
    send(K_FIND, 0, 12345);
    send(K_ERASE, 1, 0);
    send(K_UNUSED, 0, -1);
    send(K_POP_FRONT, 0, 0);
    send(K_POP_BACK, 0, 0);
    wait_drained();
  endtask

  task automatic test_full_list();
    while (list_count < CAPACITY) send(K_PUSH_BACK, 0, list_count - 8);
    send(K_PUSH_BACK, 0, 1);
    send(K_PUSH_FRONT, 0, 1);
    send(K_INSERT, 0, 1);
    send(K_INSERT, 17, 1);
    send(K_FIND, 0, list_model[CAPACITY-1]);
    send(K_ERASE, CAPACITY - 1, 0);
    send(K_ERASE, CAPACITY - 1, 0);
    send(K_INSERT, CAPACITY - 1, 32'sh7fff_ffff);
    send(K_FIND, 0, 32'sh7fff_ffff);
    while (list_count > 0) send(K_POP_FRONT, 0, 0);
    wait_drained();
  endtask

  task automatic test_random(int items, int idle_pct, int stall_rate);
    logic [KIND_W-1:0]       kind;
    int                      pos;
    logic signed [VAL_W-1:0] value;
    send_idle_pct = idle_pct;
    stall_pct = stall_rate;
    repeat (items) begin
      if (list_count == CAPACITY && $urandom_range(3) == 0) grow = 1'b0;
      if (list_count == 0 && $urandom_range(3) == 0) grow = 1'b1;
      kind = pick_kind();
      if ($urandom_range(9) < 8) pos = $urandom_range(list_count);
      else pos = $urandom_range(31);
      if (kind == K_FIND && list_count > 0 && $urandom_range(3) != 0)
        value = list_model[$urandom_range(list_count - 1)];
      else
        value = pick_value();
      send(kind, pos, value);
    end
    wait_drained();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random(125, 0, 0);
    test_random(125, 70, 0);
    test_random(125, 0, 70);
    test_random(115, 22, 22);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ordered_list_store_test: clean");
    end else begin
      $display("ordered_list_store_test: errors");
    end
    $finish;
  end

endmodule
